[rtl/cpm_pkg.sv]
// Shared widths, map codes and breakpoint tables for the colormap pixel mapper.
`default_nettype none

package cpm_pkg;

    localparam int LEVEL_W         = 16;
    localparam int LEVEL_FRAC_BITS = 12;
    localparam int MAX_BREAKPOINTS = 9;
    localparam int MODE_W          = 3;
    localparam int CH_W            = 8;

    // level rescaled to Q16 for the table maps
    localparam int T16_SH = 16 - LEVEL_FRAC_BITS;
    localparam int T16_W  = LEVEL_W + T16_SH + 1;

    localparam int X_W      = 17;
    localparam int C_W      = 27;
    localparam int D_W      = 14;
    localparam int RCP_W    = 20;
    localparam int A_W      = 17;
    localparam int A_SH     = 16;
    localparam int DELTA_W  = C_W + 1;
    localparam int K_W      = 14;
    localparam int K_SH     = 32;
    localparam int Q_W      = 9;
    localparam int TAB_ROWS = 9;
    localparam int ROW_W    = $clog2(TAB_ROWS);
    localparam int NR_W     = $clog2(TAB_ROWS + 1);

    localparam logic [C_W-1:0]  CUNIT  = C_W'(100000000);
    localparam logic [C_W-1:0]  CHALF  = C_W'(50000000);
    localparam logic [A_W-1:0]  A_ONE  = A_W'(65536);
    localparam logic [CH_W-1:0] CH_MAX = CH_W'(255);

    // floor(255 * 2^32 / 1e8): quotient estimate, off by at most one below
    localparam logic [K_W-1:0] SCALE_K = K_W'((64'd255 << K_SH) / 64'd100000000);

    // rounded reciprocals 2^32 / segment width
    localparam logic [RCP_W-1:0] RCP_8K    = RCP_W'((64'd4294967296 + 64'd4096) / 64'd8192);
    localparam logic [RCP_W-1:0] RCP_16K   = RCP_W'((64'd4294967296 + 64'd8192) / 64'd16384);
    localparam logic [RCP_W-1:0] RCP_HSV_S = RCP_W'((64'd4294967296 + 64'd5461) / 64'd10922);
    localparam logic [RCP_W-1:0] RCP_HSV_L = RCP_W'((64'd4294967296 + 64'd5461) / 64'd10923);

    typedef enum logic [MODE_W-1:0] {
        CM_MONO     = 3'd0,
        CM_MONO_INV = 3'd1,
        CM_MONO_PER = 3'd2,
        CM_HSV      = 3'd3,
        CM_JET      = 3'd4,
        CM_SMOOTH   = 3'd5,
        CM_PM       = 3'd6
    } t_cm_mode;

    // channel 0 red, 1 green, 2 blue
    typedef logic [2:0][C_W-1:0] t_rgb_c;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ROW_W-1:0]  row;
        logic              hold;
        logic [D_W-1:0]    offs;
    } t_seg;

    function automatic t_rgb_c rgb(input logic [C_W-1:0] r, input logic [C_W-1:0] g,
                                   input logic [C_W-1:0] b);
        return {b, g, r};
    endfunction

    function automatic logic is_table(input logic [MODE_W-1:0] mode);
        logic t;
        unique case (t_cm_mode'(mode))
            CM_HSV, CM_SMOOTH, CM_PM: t = 1'b1;
            default:                  t = 1'b0;
        endcase
        return t;
    endfunction

    // rows in use: table length, capped at MAX_BREAKPOINTS
    function automatic logic [NR_W-1:0] tab_rows(input logic [MODE_W-1:0] mode);
        int n;
        unique case (t_cm_mode'(mode))
            CM_HSV:    n = 6;
            CM_SMOOTH: n = 9;
            CM_PM:     n = 5;
            default:   n = 1;
        endcase
        if (n > MAX_BREAKPOINTS) begin
            n = MAX_BREAKPOINTS;
        end
        return NR_W'(n);
    endfunction

    function automatic logic [X_W-1:0] bp_x(input logic [MODE_W-1:0] mode,
                                            input logic [ROW_W-1:0] row);
        logic [X_W-1:0] x;
        x = '0;
        unique case (t_cm_mode'(mode))
            CM_HSV: begin
                unique case (row)
                    ROW_W'(0): x = X_W'(10923);
                    ROW_W'(1): x = X_W'(21845);
                    ROW_W'(2): x = X_W'(32768);
                    ROW_W'(3): x = X_W'(43691);
                    ROW_W'(4): x = X_W'(54613);
                    ROW_W'(5): x = X_W'(65536);
                    default:   x = '0;
                endcase
            end
            CM_SMOOTH: x = X_W'(row) << 13;
            CM_PM:     x = X_W'(row) << 14;
            default:   x = '0;
        endcase
        return x;
    endfunction

    function automatic logic [RCP_W-1:0] bp_rcp(input logic [MODE_W-1:0] mode,
                                                input logic [ROW_W-1:0] row);
        logic [RCP_W-1:0] r;
        r = '0;
        unique case (t_cm_mode'(mode))
            CM_HSV: begin
                unique case (row)
                    ROW_W'(0): r = RCP_HSV_S;
                    ROW_W'(1): r = RCP_HSV_L;
                    ROW_W'(2): r = RCP_HSV_L;
                    ROW_W'(3): r = RCP_HSV_S;
                    ROW_W'(4): r = RCP_HSV_L;
                    default:   r = '0;
                endcase
            end
            CM_SMOOTH: r = (row < ROW_W'(8)) ? RCP_8K : '0;
            CM_PM:     r = (row < ROW_W'(4)) ? RCP_16K : '0;
            default:   r = '0;
        endcase
        return r;
    endfunction

    function automatic t_rgb_c bp_c(input logic [MODE_W-1:0] mode,
                                    input logic [ROW_W-1:0] row);
        t_rgb_c c;
        c = '0;
        unique case (t_cm_mode'(mode))
            CM_HSV: begin
                unique case (row)
                    ROW_W'(0): c = rgb(CUNIT, '0, '0);
                    ROW_W'(1): c = rgb(CUNIT, CUNIT, '0);
                    ROW_W'(2): c = rgb('0, CUNIT, '0);
                    ROW_W'(3): c = rgb('0, CUNIT, CUNIT);
                    ROW_W'(4): c = rgb('0, '0, CUNIT);
                    ROW_W'(5): c = rgb(CUNIT, '0, '0);
                    default:   c = '0;
                endcase
            end
            CM_SMOOTH: begin
                unique case (row)
                    ROW_W'(0): c = rgb(C_W'(26710521), C_W'(3311059),  C_W'(61881550));
                    ROW_W'(1): c = rgb(C_W'(14990781), C_W'(28892902), C_W'(59136956));
                    ROW_W'(2): c = rgb(C_W'(16689640), C_W'(41027528), C_W'(50959299));
                    ROW_W'(3): c = rgb(C_W'(19159194), C_W'(51638400), C_W'(47597744));
                    ROW_W'(4): c = rgb(C_W'(16400433), C_W'(63146734), C_W'(39450263));
                    ROW_W'(5): c = rgb(C_W'(37045520), C_W'(72530195), C_W'(18639333));
                    ROW_W'(6): c = rgb(C_W'(72692898), C_W'(75698787), C_W'(16919540));
                    ROW_W'(7): c = rgb(C_W'(99505988), C_W'(78542889), C_W'(32106514));
                    ROW_W'(8): c = rgb(C_W'(98680727), C_W'(95697596), C_W'(12661626));
                    default:   c = '0;
                endcase
            end
            CM_PM: begin
                unique case (row)
                    ROW_W'(0): c = rgb('0, '0, CHALF);
                    ROW_W'(1): c = rgb('0, '0, CUNIT);
                    ROW_W'(2): c = rgb(CUNIT, CUNIT, CUNIT);
                    ROW_W'(3): c = rgb(CUNIT, '0, '0);
                    ROW_W'(4): c = rgb(CHALF, '0, '0);
                    default:   c = '0;
                endcase
            end
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/cpm_lerp.sv]
// Two-stage interpolator: segment weight from reciprocal, then blend of breakpoint colors.
`default_nettype none

module cpm_lerp (
    input  logic            i_clk,
    input  cpm_pkg::t_seg   i_seg,
    output cpm_pkg::t_rgb_c o_c
);
    import cpm_pkg::*;

    localparam int PR_W = D_W + RCP_W;
    localparam int AR_W = PR_W - A_SH;
    localparam int M_W  = A_W + 1 + DELTA_W;

    logic [PR_W-1:0]           prod;
    logic [AR_W-1:0]           a_raw;
    logic [A_W-1:0]            a;
    t_rgb_c                    c0;
    t_rgb_c                    c1;
    logic signed [DELTA_W-1:0] dl [3];

    logic [A_W-1:0]            r_a;
    t_rgb_c                    r_c0;
    logic signed [DELTA_W-1:0] r_dl [3];

    logic signed [M_W-1:0]     m [3];
    logic signed [M_W-1:0]     s [3];
    t_rgb_c                    r_c;

    // weight a = d * R >> 16, clamped to one; held rows take the row color as is
    assign prod  = PR_W'(i_seg.offs) * PR_W'(bp_rcp(i_seg.mode, i_seg.row));
    assign a_raw = prod[PR_W-1:A_SH];
    assign c0    = bp_c(i_seg.mode, i_seg.row);
    assign c1    = bp_c(i_seg.mode, i_seg.row + ROW_W'(1));

    always_comb begin
        if (i_seg.hold) begin
            a = '0;
        end else if (a_raw > AR_W'(A_ONE)) begin
            a = A_ONE;
        end else begin
            a = a_raw[A_W-1:0];
        end
        for (int k = 0; k < 3; k++) begin
            dl[k] = $signed({1'b0, c1[k]}) - $signed({1'b0, c0[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        r_a  <= a;
        r_c0 <= c0;
        for (int k = 0; k < 3; k++) begin
            r_dl[k] <= dl[k];
        end
    end

    // ((1-a)*c0 + a*c1) >> 16 rewritten as c0 + floor(a*(c1-c0) / 2^16)
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            m[k] = M_W'($signed({1'b0, r_a})) * M_W'(r_dl[k]);
            s[k] = $signed(M_W'(r_c0[k])) + (m[k] >>> A_SH);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_c[k] <= s[k][C_W-1:0];
        end
    end

    assign o_c = r_c;

endmodule

`default_nettype wire

[rtl/cpm_scale.sv]
// Two-stage channel scaler: floor(255 * c / 1e8) by reciprocal estimate and one correction.
`default_nettype none

module cpm_scale (
    input  logic                       i_clk,
    input  logic [cpm_pkg::C_W-1:0]    i_c,
    output logic [cpm_pkg::CH_W-1:0]   o_byte
);
    import cpm_pkg::*;

    localparam int P_W = C_W + K_W;
    localparam int Y_W = C_W + CH_W;
    localparam int M_W = C_W + Q_W;

    logic [P_W-1:0]  prod;
    logic [Q_W-1:0]  r_q;
    logic [C_W-1:0]  r_c;
    logic [Y_W-1:0]  y;
    logic [M_W-1:0]  m;
    logic [M_W-1:0]  rem;
    logic [Q_W:0]    q;
    logic [CH_W-1:0] r_byte;

    assign prod = P_W'(i_c) * P_W'(SCALE_K);

    always_ff @(posedge i_clk) begin
        r_q <= Q_W'(prod >> K_SH);
        r_c <= i_c;
    end

    // estimate is exact or one low: bump it when the remainder reaches 1e8
    assign y   = Y_W'(r_c) * Y_W'(CH_MAX);
    assign m   = M_W'(r_q) * M_W'(CUNIT);
    assign rem = M_W'(y) - m;
    assign q   = (Q_W + 1)'(r_q) + {{Q_W{1'b0}}, (rem >= M_W'(CUNIT))};

    always_ff @(posedge i_clk) begin
        r_byte <= (q > (Q_W + 1)'(CH_MAX)) ? CH_MAX : q[CH_W-1:0];
    end

    assign o_byte = r_byte;

endmodule

`default_nettype wire

[rtl/colormap_pixel_mapper_top.sv]
// Colormap pixel mapper: signed level in, 8-bit RGB pixel out, one of seven maps.
// Pipeline: six register stages, among them the two interpolator stages and the two
//   scaler stages of the table path.
// Throughput: one word per clock; busy stays low and results are not held off.
// Reset: synchronous, active low; clears the valid pipeline and selects the jet map.
`default_nettype none

module colormap_pixel_mapper_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [cpm_pkg::LEVEL_W-1:0]  i_level,
    input  logic                                i_mode_we,
    input  logic [cpm_pkg::MODE_W-1:0]          i_color_map_mode,
    output logic                                o_valid,
    output logic [cpm_pkg::CH_W-1:0]            o_red,
    output logic [cpm_pkg::CH_W-1:0]            o_green,
    output logic [cpm_pkg::CH_W-1:0]            o_blue
);
    import cpm_pkg::*;

    localparam int NSTG = 5;
    localparam int R_W  = LEVEL_W + 2;
    localparam int V_W  = LEVEL_FRAC_BITS + 1;
    localparam int P_W  = V_W + CH_W;

    localparam logic signed [R_W-1:0] V_ONE  = R_W'(1 << LEVEL_FRAC_BITS);
    localparam logic signed [R_W-1:0] V_HALF = R_W'(1 << (LEVEL_FRAC_BITS - 1));
    localparam logic signed [R_W-1:0] V_E    = R_W'(1 << (LEVEL_FRAC_BITS - 3));
    localparam logic signed [R_W-1:0] V_E3   = R_W'(3 << (LEVEL_FRAC_BITS - 3));
    localparam logic signed [R_W-1:0] V_E5   = R_W'(5 << (LEVEL_FRAC_BITS - 3));
    localparam logic signed [R_W-1:0] V_E7   = R_W'(7 << (LEVEL_FRAC_BITS - 3));

    logic [MODE_W-1:0]         r_mode;

    logic signed [R_W-1:0]     ts;
    logic signed [R_W-1:0]     vr;
    logic signed [R_W-1:0]     vg;
    logic signed [R_W-1:0]     vb;
    logic signed [T16_W-1:0]   t16;
    logic signed [T16_W-1:0]   x_row;
    logic [NR_W-1:0]           n_eff;
    logic [ROW_W-1:0]          srch_row;
    logic                      srch_hold;
    logic [D_W-1:0]            srch_offs;

    logic [NSTG-1:0]           r_vld;
    logic [NSTG-1:0]           r_tab;
    t_seg                      r_seg;
    logic [2:0][V_W-1:0]       r_v;
    logic [2:0][CH_W-1:0]      rb;
    logic [2:0][CH_W-1:0]      r_rb [NSTG-1];

    t_rgb_c                    lerp_c;
    logic [2:0][CH_W-1:0]      sc_byte;

    logic                      r_out_vld;
    logic [2:0][CH_W-1:0]      r_px;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= CM_JET;
        end else if (i_mode_we) begin
            r_mode <= i_color_map_mode;
        end
    end

    // stage 1: ramp and jet values in the level's own format
    assign ts = R_W'(i_level);

    always_comb begin
        vr = '0;
        vg = '0;
        vb = '0;
        unique case (t_cm_mode'(r_mode))
            CM_MONO: begin
                if (ts < 0) begin
                    vr = V_ONE;
                end else if (ts < V_ONE) begin
                    vr = V_ONE - ts;
                end
                vg = vr;
                vb = vr;
            end
            CM_MONO_INV: begin
                if (ts < 0) begin
                    vr = '0;
                end else if (ts < V_ONE) begin
                    vr = ts;
                end else begin
                    vr = V_ONE;
                end
                vg = vr;
                vb = vr;
            end
            CM_MONO_PER: begin
                if (ts < 0) begin
                    vr = V_ONE;
                end else if (ts <= V_HALF) begin
                    vr = ts <<< 1;
                end else if (ts <= V_ONE) begin
                    vr = (V_ONE <<< 1) - (ts <<< 1);
                end
                vg = vr;
                vb = vr;
            end
            CM_HSV, CM_SMOOTH, CM_PM: begin
                vr = '0;
            end
            default: begin
                // jet, and the spare code
                if (ts < 0) begin
                    vb = V_HALF;
                end else if (ts < V_E) begin
                    vb = V_HALF + (ts <<< 2);
                end else if (ts < V_E3) begin
                    vb = V_ONE;
                    vg = (ts - V_E) <<< 2;
                end else if (ts < V_E5) begin
                    vg = V_ONE;
                    vr = (ts - V_E3) <<< 2;
                    vb = V_ONE - ((ts - V_E3) <<< 2);
                end else if (ts < V_E7) begin
                    vr = V_ONE;
                    vg = V_ONE - ((ts - V_E5) <<< 2);
                end else if (ts < V_ONE) begin
                    vr = V_ONE - ((ts - V_E7) <<< 2);
                end else begin
                    vr = V_HALF;
                end
            end
        endcase
    end

    // stage 1: breakpoint search on the Q16 level
    assign t16 = T16_W'(i_level) <<< T16_SH;

    always_comb begin
        n_eff    = tab_rows(r_mode);
        srch_row = '0;
        for (int k = 1; k < TAB_ROWS; k++) begin
            if ((NR_W'(k) < n_eff) && (t16 >= $signed(T16_W'(bp_x(r_mode, ROW_W'(k)))))) begin
                srch_row = ROW_W'(k);
            end
        end
        x_row     = $signed(T16_W'(bp_x(r_mode, srch_row)));
        // clamp below the first breakpoint and at or past the last one
        srch_hold = (t16 <= $signed(T16_W'(bp_x(r_mode, '0))))
                 || (NR_W'(srch_row) == n_eff - NR_W'(1));
        srch_offs = D_W'(t16 - x_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], start && !busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tab  <= {r_tab[NSTG-2:0], is_table(r_mode)};
        r_seg  <= '{mode: r_mode, row: srch_row, hold: srch_hold, offs: srch_offs};
        r_v[0] <= vr[V_W-1:0];
        r_v[1] <= vg[V_W-1:0];
        r_v[2] <= vb[V_W-1:0];
    end

    // stage 2: ramp channels to bytes, then delay them alongside the table path
    always_comb begin
        logic [P_W-1:0] p;
        logic [P_W-1:0] pb;
        for (int k = 0; k < 3; k++) begin
            p     = (P_W'(r_v[k]) << CH_W) - P_W'(r_v[k]);
            pb    = p >> LEVEL_FRAC_BITS;
            rb[k] = (pb > P_W'(CH_MAX)) ? CH_MAX : pb[CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rb[0] <= rb;
        for (int k = 1; k < NSTG - 1; k++) begin
            r_rb[k] <= r_rb[k-1];
        end
    end

    cpm_lerp u_lerp (
        .i_clk (i_clk),
        .i_seg (r_seg),
        .o_c   (lerp_c)
    );

    for (genvar g = 0; g < 3; g++) begin : g_scale
        cpm_scale u_scale (
            .i_clk  (i_clk),
            .i_c    (lerp_c[g]),
            .o_byte (sc_byte[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_px <= r_tab[NSTG-1] ? sc_byte : r_rb[NSTG-2];
    end

    assign o_valid = r_out_vld;
    assign o_red   = r_px[0];
    assign o_green = r_px[1];
    assign o_blue  = r_px[2];

    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##6 o_valid)
        else $error("accepted word did not leave six edges later");

    a_lat_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 6))
        else $error("result word without a matching accepted word");

    a_row_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && r_tab[0]) |-> (NR_W'(r_seg.row) < tab_rows(r_seg.mode)))
        else $error("breakpoint row past the rows in use");

endmodule

`default_nettype wire

[test/colormap_pixel_mapper_top_tb.sv]
// Self-checking testbench for the colormap pixel mapper: random levels through every map.
`default_nettype none

module colormap_pixel_mapper_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpm_pkg::*;

    localparam longint CU = 100000000;
    localparam int N_PHASES = 14;
    localparam int PHASE_LEN = 96;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pix;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic [MODE_W-1:0]         mode;
        t_pix                      pix;
    } t_pix_exp;

    class pixel_board;
        t_pix_exp          pixel_q[$];
        logic [MODE_W-1:0] mode;
        int                n_err;
        int                n_levels;
        int                n_pixels;

        function new();
            mode = CM_JET;
            n_err = 0;
            n_levels = 0;
            n_pixels = 0;
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            n_err++;
        endtask

        function logic [CH_W-1:0] ramp_chan(input longint v);
            longint p;
            if (v < 0) begin
                v = 0;
            end
            p = (255 * v) >>> LEVEL_FRAC_BITS;
            return (p > 255) ? CH_MAX : CH_W'(p);
        endfunction

        function logic [CH_W-1:0] color_chan(input longint c);
            longint p;
            p = (255 * c) / CU;
            return (p > 255) ? CH_MAX : CH_W'(p);
        endfunction

        function t_pix color_pix(input longint r, input longint g, input longint b);
            t_pix p;
            p.red = color_chan(r);
            p.green = color_chan(g);
            p.blue = color_chan(b);
            return p;
        endfunction

        // breakpoint row i of a table map: Q16 position and colors in units of 1e-8
        function void tab_row(input logic [MODE_W-1:0] m, input int i, output longint x,
                              output longint cr, output longint cg, output longint cb);
            x = 0;
            cr = 0;
            cg = 0;
            cb = 0;
            case (m)
                CM_HSV: begin
                    case (i)
                        0: begin x = 10923; cr = CU; end
                        1: begin x = 21845; cr = CU; cg = CU; end
                        2: begin x = 32768; cg = CU; end
                        3: begin x = 43691; cg = CU; cb = CU; end
                        4: begin x = 54613; cb = CU; end
                        default: begin x = 65536; cr = CU; end
                    endcase
                end
                CM_SMOOTH: begin
                    x = 8192 * i;
                    case (i)
                        0: begin cr = 26710521; cg = 3311059;  cb = 61881550; end
                        1: begin cr = 14990781; cg = 28892902; cb = 59136956; end
                        2: begin cr = 16689640; cg = 41027528; cb = 50959299; end
                        3: begin cr = 19159194; cg = 51638400; cb = 47597744; end
                        4: begin cr = 16400433; cg = 63146734; cb = 39450263; end
                        5: begin cr = 37045520; cg = 72530195; cb = 18639333; end
                        6: begin cr = 72692898; cg = 75698787; cb = 16919540; end
                        7: begin cr = 99505988; cg = 78542889; cb = 32106514; end
                        default: begin cr = 98680727; cg = 95697596; cb = 12661626; end
                    endcase
                end
                default: begin
                    x = 16384 * i;
                    case (i)
                        0: cb = CU / 2;
                        1: cb = CU;
                        2: begin cr = CU; cg = CU; cb = CU; end
                        3: cr = CU;
                        default: cr = CU / 2;
                    endcase
                end
            endcase
        endfunction

        function t_pix table_pix(input logic [MODE_W-1:0] m, input longint t16);
            longint x0, x1, r0, g0, b0, r1, g1, b1, w, rcp, d, a;
            int     n;
            int     i;
            bit     adv;
            t_pix   p;
            case (m)
                CM_HSV:    n = 6;
                CM_SMOOTH: n = 9;
                default:   n = 5;
            endcase
            if (n > MAX_BREAKPOINTS) begin
                n = MAX_BREAKPOINTS;
            end
            tab_row(m, 0, x0, r0, g0, b0);
            if (t16 <= x0) begin
                return color_pix(r0, g0, b0);
            end
            i = 0;
            adv = 1'b1;
            while (adv && i + 1 < n) begin
                tab_row(m, i + 1, x1, r1, g1, b1);
                if (t16 >= x1) begin
                    i++;
                end else begin
                    adv = 1'b0;
                end
            end
            if (i + 1 >= n) begin
                tab_row(m, n - 1, x1, r1, g1, b1);
                return color_pix(r1, g1, b1);
            end
            tab_row(m, i, x0, r0, g0, b0);
            tab_row(m, i + 1, x1, r1, g1, b1);
            // segment weight through a rounded reciprocal of the width
            w = x1 - x0;
            rcp = (64'sd4294967296 + w / 2) / w;
            d = t16 - x0;
            a = (d * rcp) >>> 16;
            if (a > 65536) begin
                a = 65536;
            end
            p.red = color_chan(((65536 - a) * r0 + a * r1) >>> 16);
            p.green = color_chan(((65536 - a) * g0 + a * g1) >>> 16);
            p.blue = color_chan(((65536 - a) * b0 + a * b1) >>> 16);
            return p;
        endfunction

        function t_pix map_level(input logic signed [LEVEL_W-1:0] level);
            longint t, one, e, v, r, g, b;
            t_pix   p;
            t = longint'(level);
            one = longint'(1) << LEVEL_FRAC_BITS;
            e = one >>> 3;
            r = 0;
            g = 0;
            b = 0;
            case (mode)
                CM_MONO, CM_MONO_INV, CM_MONO_PER: begin
                    if (mode == CM_MONO) begin
                        v = (t < 0) ? one : ((t < one) ? one - t : 0);
                    end else if (mode == CM_MONO_INV) begin
                        v = (t < 0) ? 0 : ((t < one) ? t : one);
                    end else if (t < 0) begin
                        v = one;
                    end else if (t <= one / 2) begin
                        v = 2 * t;
                    end else if (t <= one) begin
                        v = 2 * one - 2 * t;
                    end else begin
                        v = 0;
                    end
                    p.red = ramp_chan(v);
                    p.green = p.red;
                    p.blue = p.red;
                end
                CM_HSV, CM_SMOOTH, CM_PM: begin
                    p = table_pix(mode, t * (longint'(1) << (16 - LEVEL_FRAC_BITS)));
                end
                default: begin
                    if (t < 0) begin
                        b = one / 2;
                    end else if (t < e) begin
                        b = one / 2 + 4 * t;
                    end else if (t < 3 * e) begin
                        b = one;
                        g = 4 * (t - e);
                    end else if (t < 5 * e) begin
                        g = one;
                        r = 4 * (t - 3 * e);
                        b = one - 4 * (t - 3 * e);
                    end else if (t < 7 * e) begin
                        r = one;
                        g = one - 4 * (t - 5 * e);
                    end else if (t < one) begin
                        r = one - 4 * (t - 7 * e);
                    end else begin
                        r = one / 2;
                    end
                    p.red = ramp_chan(r);
                    p.green = ramp_chan(g);
                    p.blue = ramp_chan(b);
                end
            endcase
            return p;
        endfunction

        function void note_level(input logic signed [LEVEL_W-1:0] level);
            t_pix_exp x;
            x.level = level;
            x.mode = mode;
            x.pix = map_level(level);
            pixel_q.push_back(x);
            n_levels++;
        endfunction

        task check_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                         input logic [CH_W-1:0] b);
            t_pix_exp x;
            n_pixels++;
            if (pixel_q.size() == 0) begin
                report($sformatf("pixel %0d/%0d/%0d with no level pending", r, g, b));
            end else begin
                x = pixel_q.pop_front();
                if (r !== x.pix.red) begin
                    report($sformatf("mode %0d level %0d red %0d, want %0d",
                                     x.mode, x.level, r, x.pix.red));
                end
                if (g !== x.pix.green) begin
                    report($sformatf("mode %0d level %0d green %0d, want %0d",
                                     x.mode, x.level, g, x.pix.green));
                end
                if (b !== x.pix.blue) begin
                    report($sformatf("mode %0d level %0d blue %0d, want %0d",
                                     x.mode, x.level, b, x.pix.blue));
                end
            end
        endtask
    endclass

    // three corner levels per mode code, indexed by the code
    localparam shortint CORNER_LV [0:7][0:2] = '{
        '{-16'sd1, 16'sd0, 16'sd4096},
        '{-16'sd32768, 16'sd4095, 16'sd32767},
        '{16'sd2048, 16'sd2049, 16'sd4097},
        '{16'sd682, 16'sd683, 16'sd3413},
        '{16'sd511, 16'sd1536, 16'sd3584},
        '{16'sd0, 16'sd2047, 16'sd4096},
        '{16'sd1024, 16'sd3072, 16'sd4095},
        '{16'sd2560, 16'sd3583, 16'sd32767}
    };

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic signed [LEVEL_W-1:0] i_level;
    logic                      i_mode_we;
    logic [MODE_W-1:0]         i_color_map_mode;
    logic                      o_valid;
    logic [CH_W-1:0]           o_red;
    logic [CH_W-1:0]           o_green;
    logic [CH_W-1:0]           o_blue;

    pixel_board board;
    int         n_writes;

    colormap_pixel_mapper_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_level          (i_level),
        .i_mode_we        (i_mode_we),
        .i_color_map_mode (i_color_map_mode),
        .o_valid          (o_valid),
        .o_red            (o_red),
        .o_green          (o_green),
        .o_blue           (o_blue)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            board.mode = CM_JET;
        end else begin
            if (o_valid) begin
                board.check_pixel(o_red, o_green, o_blue);
            end
            if (i_mode_we) begin
                board.mode = i_color_map_mode;
            end
            if (start && !busy) begin
                board.note_level(i_level);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic put_level(input logic signed [LEVEL_W-1:0] lvl, input bit allow_gap);
        if (allow_gap && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        start <= 1'b1;
        i_level <= lvl;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic set_mode(input logic [MODE_W-1:0] m);
        start <= 1'b0;
        // drain so that no pixel in flight sees the new map
        while (board.pixel_q.size() != 0) begin
            @(negedge i_clk);
        end
        i_mode_we <= 1'b1;
        i_color_map_mode <= m;
        @(negedge i_clk);
        i_mode_we <= 1'b0;
        n_writes++;
    endtask

    function automatic logic signed [LEVEL_W-1:0] rand_level();
        int sel;
        int v;
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            v = $urandom_range(0, 4608) - 256;
        end else if (sel < 75) begin
            v = $urandom;
        end else if (sel < 90) begin
            // land near a segment edge
            if ($urandom_range(0, 1) == 0) begin
                v = $urandom_range(0, 16) * 256;
            end else begin
                v = $urandom_range(1, 5) * 4096 / 6;
            end
            v = v + $urandom_range(0, 4) - 2;
        end else begin
            case ($urandom_range(0, 4))
                0: v = -32768;
                1: v = 32767;
                2: v = -1;
                3: v = 0;
                default: v = 4096;
            endcase
        end
        return LEVEL_W'(v);
    endfunction

    initial begin
        #2_000_000;
        $display("[colormap_pixel_mapper_top] ERROR");
        $finish;
    end

    initial begin
        logic [MODE_W-1:0] m;
        board = new();
        n_writes = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_level = '0;
        i_mode_we = 1'b0;
        i_color_map_mode = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // corner levels: jet straight from reset, then every other code
        for (int k = 0; k < 3; k++) begin
            put_level(CORNER_LV[CM_JET][k], 1'b0);
        end
        for (int c = 0; c < 8; c++) begin
            m = MODE_W'(c);
            if (m != CM_JET) begin
                set_mode(m);
                for (int k = 0; k < 3; k++) begin
                    put_level(CORNER_LV[c][k], 1'b0);
                end
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            m = (p < 8) ? MODE_W'(7 - p) : MODE_W'($urandom_range(0, 7));
            set_mode(m);
            for (int k = 0; k < PHASE_LEN; k++) begin
                put_level(rand_level(), p != N_PHASES - 1);
            end
        end
        start <= 1'b0;

        while (board.pixel_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("levels sent %0d over %0d map writes (all eight mode codes), pixels seen %0d",
                 board.n_levels, n_writes, board.n_pixels);
        if (board.n_err == 0) begin
            $display("[colormap_pixel_mapper_top] OK");
        end else begin
            $display("%0d mismatches", board.n_err);
            $display("[colormap_pixel_mapper_top] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
